FILE: src/vfpa_pkg.sv
// Package of the video frame packet assembler: register indexes, reset values,
// protocol constants, header byte offsets and the structs passed between modules.
// No dependencies.
`default_nettype none

package vfpa_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 48;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_MAC       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEST_MAC         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_IP        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DEST_IP          = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UDP_PORT_NUMBER  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_UDP_LENGTH_VALUE = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_MAGIC    = 3'd6;

  // Register reset values
  localparam logic [47:0] RST_SOURCE_MAC       = 48'h0200_0000_0002;
  localparam logic [47:0] RST_DEST_MAC         = 48'h0200_0000_0003;
  localparam logic [31:0] RST_SOURCE_IP        = 32'h0a0a_0f02;
  localparam logic [31:0] RST_DEST_IP          = 32'h0a0a_0f03;
  localparam logic [15:0] RST_UDP_PORT_NUMBER  = 16'd5602;
  localparam logic [15:0] RST_UDP_LENGTH_VALUE = 16'd1480;
  localparam logic [31:0] RST_PAYLOAD_MAGIC    = 32'h5043_414d;

  // Protocol constants
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IP_VERSION_4   = 4'd4;
  localparam logic [3:0]  IP_MIN_IHL     = 4'd5;
  localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;

  // Absolute byte positions (last byte of each field)
  localparam int POS_DEST_MAC_END  = 5;
  localparam int POS_SRC_MAC_END   = 11;
  localparam int POS_ETHERTYPE_END = 13;
  localparam int POS_IP_VER_IHL    = 14;
  localparam int POS_IP_PROTO      = 23;
  localparam int POS_IP_SRC_END    = 29;
  localparam int POS_IP_DST_END    = 33;
  localparam int POS_UDP_MIN       = 34;
  localparam int ETH_HDR_BYTES     = 14;
  localparam int MIN_UDP_TAIL      = 24;

  // Offsets from the UDP header start (last byte of each field)
  localparam int REL_SRC_PORT_END = 1;
  localparam int REL_DST_PORT_END = 3;
  localparam int REL_UDP_LEN_END  = 5;
  localparam int REL_MAGIC_END    = 11;
  localparam int REL_SESSION_END  = 15;
  localparam int REL_FRAME_END    = 19;
  localparam int REL_INDEX_END    = 21;
  localparam int REL_FLAGS_END    = 23;

  // Present map is held as rows of 32 flags
  localparam int MAP_SEL_W    = 5;
  localparam int MAP_ROW_BITS = 32;

  typedef struct packed {
    logic [47:0] source_mac;
    logic [47:0] dest_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] udp_port_number;
    logic [15:0] udp_length_value;
    logic [31:0] payload_magic;
  } vfpa_cfg_t;

  // Packet summary handed from the parser to the frame tracker at packet end
  typedef struct packed {
    logic        eop;
    logic        valid;
    logic [31:0] session;
    logic [31:0] frame;
    logic [15:0] index;
  } vfpa_parse_t;

  typedef struct packed {
    logic        header_valid;
    logic [31:0] session_value;
    logic [31:0] frame_value;
    logic [15:0] index_value;
    logic        packet_accepted;
    logic        oversize;
    logic [10:0] collected_count;
    logic        frame_complete;
    logic [21:0] frame_byte_total;
  } vfpa_result_t;

endpackage

`default_nettype wire

FILE: src/vfpa_if.sv
// Channel interfaces of the video frame packet assembler: byte input, result
// output and configuration write. Depends on vfpa_pkg.
`default_nettype none

interface vfpa_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       end_of_packet;

  modport source (output valid, packet_byte, end_of_packet, input ready);
  modport sink   (input valid, packet_byte, end_of_packet, output ready);
endinterface

interface vfpa_result_if;
  logic        valid;
  logic        ready;
  logic        header_valid;
  logic [31:0] session_value;
  logic [31:0] frame_value;
  logic [15:0] index_value;
  logic        packet_accepted;
  logic        oversize;
  logic [10:0] collected_count;
  logic        frame_complete;
  logic [21:0] frame_byte_total;

  modport source (output valid, header_valid, session_value, frame_value, index_value,
                  packet_accepted, oversize, collected_count, frame_complete,
                  frame_byte_total, input ready);
  modport sink   (input valid, header_valid, session_value, frame_value, index_value,
                  packet_accepted, oversize, collected_count, frame_complete,
                  frame_byte_total, output ready);
endinterface

interface vfpa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [vfpa_pkg::CFG_INDEX_W-1:0] index;
  logic [vfpa_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/vfpa_header_parser.sv
// Byte-wise header parser: checks Ethernet, IPv4, UDP and payload header fields
// as the bytes pass and captures session, frame and index. Depends on vfpa_pkg.
`default_nettype none

module vfpa_header_parser #(
  parameter int PACKETS_IN_FRAME = 1280,
  parameter int POS_W            = 12
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       take,
  input  wire [7:0]                 packet_byte,
  input  wire                       end_of_packet,
  input  vfpa_pkg::vfpa_cfg_t       cfg_regs,
  output vfpa_pkg::vfpa_parse_t     info,
  output logic [POS_W-1:0]          length,
  output logic [15:0]               index_held
);

  localparam logic [POS_W-1:0] POS_CAP = {POS_W{1'b1}};

  logic [POS_W-1:0] byte_position;
  logic [47:0]      header_words_shift;
  logic [3:0]       ip_header_words;
  logic             check_failed;
  logic [31:0]      parsed_session;
  logic [31:0]      parsed_frame;
  logic [15:0]      parsed_index;
  logic             parsed_flag0;

  logic [POS_W-1:0] byte_position_next;
  logic [47:0]      header_words_shift_next;
  logic [3:0]       ip_header_words_next;
  logic             check_failed_next;
  logic [31:0]      parsed_session_next;
  logic [31:0]      parsed_frame_next;
  logic [15:0]      parsed_index_next;
  logic             parsed_flag0_next;

  logic [15:0]      lo16;
  logic [31:0]      lo32;
  logic [6:0]       udp_start;
  logic [POS_W-1:0] udp_start_ext;
  logic [POS_W-1:0] rel;

  // Field checks and captures for the byte being taken
  always_comb begin
    header_words_shift_next = {header_words_shift[39:0], packet_byte};
    lo16 = header_words_shift_next[15:0];
    lo32 = header_words_shift_next[31:0];
    check_failed_next    = check_failed;
    ip_header_words_next = ip_header_words;
    parsed_session_next  = parsed_session;
    parsed_frame_next    = parsed_frame;
    parsed_index_next    = parsed_index;
    parsed_flag0_next    = parsed_flag0;
    rel = '0;

    if (byte_position == POS_W'(vfpa_pkg::POS_DEST_MAC_END) &&
        header_words_shift_next != cfg_regs.dest_mac) check_failed_next = 1'b1;
    if (byte_position == POS_W'(vfpa_pkg::POS_SRC_MAC_END) &&
        header_words_shift_next != cfg_regs.source_mac) check_failed_next = 1'b1;
    if (byte_position == POS_W'(vfpa_pkg::POS_ETHERTYPE_END) &&
        lo16 != vfpa_pkg::ETHERTYPE_IPV4) check_failed_next = 1'b1;
    if (byte_position == POS_W'(vfpa_pkg::POS_IP_VER_IHL)) begin
      ip_header_words_next = packet_byte[3:0];
      if (packet_byte[7:4] != vfpa_pkg::IP_VERSION_4 ||
          packet_byte[3:0] < vfpa_pkg::IP_MIN_IHL) check_failed_next = 1'b1;
    end
    if (byte_position == POS_W'(vfpa_pkg::POS_IP_PROTO) &&
        packet_byte != vfpa_pkg::IP_PROTO_UDP) check_failed_next = 1'b1;
    if (byte_position == POS_W'(vfpa_pkg::POS_IP_SRC_END) &&
        lo32 != cfg_regs.source_ip) check_failed_next = 1'b1;
    if (byte_position == POS_W'(vfpa_pkg::POS_IP_DST_END) &&
        lo32 != cfg_regs.dest_ip) check_failed_next = 1'b1;

    // UDP header start follows the IP header length
    udp_start     = 7'(vfpa_pkg::ETH_HDR_BYTES) + {1'b0, ip_header_words_next, 2'b00};
    udp_start_ext = POS_W'(udp_start);

    if (byte_position >= POS_W'(vfpa_pkg::POS_UDP_MIN) && byte_position >= udp_start_ext)
    begin
      rel = byte_position - udp_start_ext;
      case (rel)
        POS_W'(vfpa_pkg::REL_SRC_PORT_END): begin
          if (lo16 != cfg_regs.udp_port_number) check_failed_next = 1'b1;
        end
        POS_W'(vfpa_pkg::REL_DST_PORT_END): begin
          if (lo16 != cfg_regs.udp_port_number) check_failed_next = 1'b1;
        end
        POS_W'(vfpa_pkg::REL_UDP_LEN_END): begin
          if (lo16 != cfg_regs.udp_length_value) check_failed_next = 1'b1;
        end
        POS_W'(vfpa_pkg::REL_MAGIC_END): begin
          if (lo32 != cfg_regs.payload_magic) check_failed_next = 1'b1;
        end
        POS_W'(vfpa_pkg::REL_SESSION_END): parsed_session_next = lo32;
        POS_W'(vfpa_pkg::REL_FRAME_END):   parsed_frame_next   = lo32;
        POS_W'(vfpa_pkg::REL_INDEX_END):   parsed_index_next   = lo16;
        POS_W'(vfpa_pkg::REL_FLAGS_END):   parsed_flag0_next   = lo16[0];
        default: ;
      endcase
    end

    // Position counter saturates well above any length that matters
    byte_position_next = (byte_position == POS_CAP) ? byte_position : byte_position + 1'b1;
  end

  // Packet summary at the final byte
  assign length     = byte_position_next;
  assign index_held = parsed_index;

  always_comb begin
    info.eop     = take & end_of_packet;
    info.valid   = !check_failed_next &&
                   byte_position_next >= udp_start_ext + POS_W'(vfpa_pkg::MIN_UDP_TAIL) &&
                   parsed_flag0_next &&
                   parsed_index_next < 16'(PACKETS_IN_FRAME);
    info.session = parsed_session_next;
    info.frame   = parsed_frame_next;
    info.index   = parsed_index_next;
  end

  // Parse state, cleared at every packet end
  always_ff @(posedge clk) begin
    if (rst || (take && end_of_packet)) begin
      byte_position      <= '0;
      header_words_shift <= '0;
      ip_header_words    <= '0;
      check_failed       <= 1'b0;
      parsed_session     <= '0;
      parsed_frame       <= '0;
      parsed_index       <= '0;
      parsed_flag0       <= 1'b0;
    end else if (take) begin
      byte_position      <= byte_position_next;
      header_words_shift <= header_words_shift_next;
      ip_header_words    <= ip_header_words_next;
      check_failed       <= check_failed_next;
      parsed_session     <= parsed_session_next;
      parsed_frame       <= parsed_frame_next;
      parsed_index       <= parsed_index_next;
      parsed_flag0       <= parsed_flag0_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/vfpa_frame_tracker.sv
// Frame tracker: keeps the candidate frame, the present map of packet indexes
// (32-flag rows in a RAM with per-row valid flags), count and byte total.
// Depends on vfpa_pkg.
`default_nettype none

module vfpa_frame_tracker #(
  parameter int PACKETS_IN_FRAME = 1280,
  parameter int MAX_PACKET_BYTES = 2048,
  parameter int POS_W            = 12
) (
  input  wire                       clk,
  input  wire                       rst,
  input  vfpa_pkg::vfpa_parse_t     info,
  input  wire [POS_W-1:0]           length,
  input  wire [15:0]                index_held,
  output vfpa_pkg::vfpa_result_t    result
);

  localparam int ROWS  = (PACKETS_IN_FRAME + vfpa_pkg::MAP_ROW_BITS - 1) /
                         vfpa_pkg::MAP_ROW_BITS;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W = $clog2(PACKETS_IN_FRAME + 1);
  localparam int CNT_X = (CNT_W > 11) ? CNT_W : 11;

  // Present map storage
  logic [vfpa_pkg::MAP_ROW_BITS-1:0] map_mem [ROWS];
  logic [vfpa_pkg::MAP_ROW_BITS-1:0] map_rdata;
  logic [ROWS-1:0]                   row_valid;
  logic [ROWS-1:0]                   row_valid_next;

  logic [CNT_W-1:0] held_count;
  logic [31:0]      candidate_session;
  logic [31:0]      candidate_frame;
  logic             candidate_present;
  logic [21:0]      byte_total;
  logic             assembly_done;

  logic [CNT_W-1:0] held_count_next;
  logic [31:0]      candidate_session_next;
  logic [31:0]      candidate_frame_next;
  logic             candidate_present_next;
  logic [21:0]      byte_total_next;
  logic             assembly_done_next;

  logic [15-vfpa_pkg::MAP_SEL_W:0]   row_full;
  logic [ROW_W-1:0]                  row_addr;
  logic [vfpa_pkg::MAP_SEL_W-1:0]    bit_sel;
  logic [vfpa_pkg::MAP_ROW_BITS-1:0] row_data;
  logic                              live;
  logic                              restart;
  logic                              present;
  logic                              match;
  logic                              over;
  logic                              accepted;
  logic                              complete;
  logic [CNT_X-1:0]                  count_ext;

  // Row of the held index; read every cycle so it is ready at packet end
  always_comb begin
    row_full = index_held[15:vfpa_pkg::MAP_SEL_W];
    row_addr = (index_held < 16'(PACKETS_IN_FRAME)) ? row_full[ROW_W-1:0] : '0;
    bit_sel  = index_held[vfpa_pkg::MAP_SEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    map_rdata <= map_mem[row_addr];
    if (accepted) begin
      map_mem[row_addr] <= row_data | (vfpa_pkg::MAP_ROW_BITS'(1) << bit_sel);
    end
  end

  // Candidate decision at packet end
  always_comb begin
    live    = info.eop && info.valid && !assembly_done;
    restart = live && info.index == '0 &&
              (held_count == '0 || info.session != candidate_session ||
               info.frame != candidate_frame);

    candidate_session_next = restart ? info.session : candidate_session;
    candidate_frame_next   = restart ? info.frame : candidate_frame;
    candidate_present_next = restart | candidate_present;

    // A restart empties the map, so stored rows read as clear
    row_data = (restart || !row_valid[row_addr]) ? '0 : map_rdata;
    present  = row_data[bit_sel];

    match    = live && candidate_present_next &&
               info.session == candidate_session_next &&
               info.frame == candidate_frame_next && !present;
    over     = match && length > POS_W'(MAX_PACKET_BYTES);
    accepted = match && !over;

    held_count_next = restart ? '0 : held_count;
    byte_total_next = restart ? '0 : byte_total;
    row_valid_next  = restart ? '0 : row_valid;
    if (accepted) begin
      held_count_next          = held_count_next + 1'b1;
      byte_total_next          = byte_total_next + 22'(length);
      row_valid_next[row_addr] = 1'b1;
    end
    complete           = accepted && held_count_next == CNT_W'(PACKETS_IN_FRAME);
    assembly_done_next = assembly_done | complete;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count        <= '0;
      candidate_session <= '0;
      candidate_frame   <= '0;
      candidate_present <= 1'b0;
      byte_total        <= '0;
      assembly_done     <= 1'b0;
      row_valid         <= '0;
    end else if (info.eop) begin
      held_count        <= held_count_next;
      candidate_session <= candidate_session_next;
      candidate_frame   <= candidate_frame_next;
      candidate_present <= candidate_present_next;
      byte_total        <= byte_total_next;
      assembly_done     <= assembly_done_next;
      row_valid         <= row_valid_next;
    end
  end

  // Result fields
  always_comb begin
    count_ext               = CNT_X'(held_count_next);
    result.header_valid     = info.valid;
    result.session_value    = info.valid ? info.session : '0;
    result.frame_value      = info.valid ? info.frame : '0;
    result.index_value      = info.valid ? info.index : '0;
    result.packet_accepted  = accepted;
    result.oversize         = over;
    result.collected_count  = count_ext[10:0];
    result.frame_complete   = complete;
    result.frame_byte_total = byte_total_next;
  end

endmodule

`default_nettype wire

FILE: src/video_frame_packet_assembler_unit.sv
// Video frame packet assembler, top level: configuration registers, parser,
// frame tracker and the result queue. Depends on vfpa_pkg, vfpa_if,
// vfpa_header_parser and vfpa_frame_tracker.
//
// Takes one Ethernet byte per clock, sustained, whenever the two-entry result
// queue has room; a packet's result is written to the queue in the cycle its
// last byte is taken and can leave on the next edge. All header checks run on
// the byte as it is taken. The present map lives in a RAM of 32-flag rows
// with a valid flag per row; the row of the captured packet index is read
// ahead of packet end, so no clearing pass is needed after reset or when
// a new candidate frame starts. Configuration writes are taken in any cycle.
`default_nettype none

module video_frame_packet_assembler_unit #(
  parameter int PACKETS_IN_FRAME = 1280,
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  wire          clk,
  input  wire          rst,
  vfpa_byte_if.sink    pkt,
  vfpa_result_if.source res,
  vfpa_cfg_if.sink     cfg
);

  localparam int POS_W_RAW = $clog2(MAX_PACKET_BYTES + 2);
  localparam int POS_W     = (POS_W_RAW < 7) ? 7 : POS_W_RAW;

  vfpa_pkg::vfpa_cfg_t    cfg_regs;
  vfpa_pkg::vfpa_parse_t  info;
  vfpa_pkg::vfpa_result_t result;
  logic [POS_W-1:0]       length;
  logic [15:0]            index_held;
  logic                   take;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.source_mac       <= vfpa_pkg::RST_SOURCE_MAC;
      cfg_regs.dest_mac         <= vfpa_pkg::RST_DEST_MAC;
      cfg_regs.source_ip        <= vfpa_pkg::RST_SOURCE_IP;
      cfg_regs.dest_ip          <= vfpa_pkg::RST_DEST_IP;
      cfg_regs.udp_port_number  <= vfpa_pkg::RST_UDP_PORT_NUMBER;
      cfg_regs.udp_length_value <= vfpa_pkg::RST_UDP_LENGTH_VALUE;
      cfg_regs.payload_magic    <= vfpa_pkg::RST_PAYLOAD_MAGIC;
    end else if (cfg.valid) begin
      case (cfg.index)
        vfpa_pkg::REG_SOURCE_MAC:       cfg_regs.source_mac       <= cfg.data[47:0];
        vfpa_pkg::REG_DEST_MAC:         cfg_regs.dest_mac         <= cfg.data[47:0];
        vfpa_pkg::REG_SOURCE_IP:        cfg_regs.source_ip        <= cfg.data[31:0];
        vfpa_pkg::REG_DEST_IP:          cfg_regs.dest_ip          <= cfg.data[31:0];
        vfpa_pkg::REG_UDP_PORT_NUMBER:  cfg_regs.udp_port_number  <= cfg.data[15:0];
        vfpa_pkg::REG_UDP_LENGTH_VALUE: cfg_regs.udp_length_value <= cfg.data[15:0];
        vfpa_pkg::REG_PAYLOAD_MAGIC:    cfg_regs.payload_magic    <= cfg.data[31:0];
        default: ;
      endcase
    end
  end

  assign take = pkt.valid & pkt.ready;

  vfpa_header_parser #(
    .PACKETS_IN_FRAME (PACKETS_IN_FRAME),
    .POS_W            (POS_W)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .packet_byte   (pkt.packet_byte),
    .end_of_packet (pkt.end_of_packet),
    .cfg_regs      (cfg_regs),
    .info          (info),
    .length        (length),
    .index_held    (index_held)
  );

  vfpa_frame_tracker #(
    .PACKETS_IN_FRAME (PACKETS_IN_FRAME),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
    .POS_W            (POS_W)
  ) u_tracker (
    .clk        (clk),
    .rst        (rst),
    .info       (info),
    .length     (length),
    .index_held (index_held),
    .result     (result)
  );

  // Two-entry result queue
  vfpa_pkg::vfpa_result_t res_q [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             occupancy;
  logic                   push;
  logic                   pop;
  vfpa_pkg::vfpa_result_t head;

  assign push      = info.eop;
  assign pop       = res.valid & res.ready;
  assign pkt.ready = (occupancy != 2'd2);
  assign res.valid = (occupancy != 2'd0);

  always_ff @(posedge clk) begin
    if (push) res_q[wr_ptr] <= result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      occupancy <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      occupancy <= occupancy + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head                 = res_q[rd_ptr];
  assign res.header_valid     = head.header_valid;
  assign res.session_value    = head.session_value;
  assign res.frame_value      = head.frame_value;
  assign res.index_value      = head.index_value;
  assign res.packet_accepted  = head.packet_accepted;
  assign res.oversize         = head.oversize;
  assign res.collected_count  = head.collected_count;
  assign res.frame_complete   = head.frame_complete;
  assign res.frame_byte_total = head.frame_byte_total;

endmodule

`default_nettype wire

FILE: tb/sv/vfpa_checker.sv
// Checker of the video frame packet assembler: watches the byte, result and
// configuration channels, predicts each packet report and compares it.
// Depends on vfpa_pkg and vfpa_if.
`default_nettype none

module vfpa_checker (
  input  logic   clk,
  input  logic   rst,
  vfpa_byte_if   pkt,
  vfpa_result_if res,
  vfpa_cfg_if    cfg,
  output int     fail_count,
  output int     pending,
  output int     checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import vfpa_pkg::*;

  localparam int PACKETS   = 1280;
  localparam int MAX_BYTES = 2048;
  localparam logic [15:0] POS_CAP = 16'hFFFF;

  // Register copies
  logic [47:0] want_src_mac, want_dst_mac;
  logic [31:0] want_src_ip, want_dst_ip, want_magic;
  logic [15:0] want_port, want_udp_len;

  // Per-packet parse state
  logic [15:0] pos;
  logic [63:0] shreg;
  logic [3:0]  ihl;
  bit          bad;
  logic [31:0] cur_session, cur_frame;
  logic [15:0] cur_index, cur_flags;

  // Candidate frame state
  logic [PACKETS-1:0] seen_idx;
  int                 held;
  logic [31:0]        cand_session, cand_frame;
  bit                 cand_live;
  logic [31:0]        total;
  bit                 done;

  vfpa_result_t expected_reports[$];
  int fails = 0;
  int shown = 0;
  int n_checked = 0;

  function automatic void clear_parse();
    pos = '0;
    shreg = '0;
    ihl = '0;
    bad = 1'b0;
    cur_session = '0;
    cur_frame = '0;
    cur_index = '0;
    cur_flags = '0;
  endfunction

  function automatic void reset_assembler();
    want_src_mac = 48'h0200_0000_0002;
    want_dst_mac = 48'h0200_0000_0003;
    want_src_ip  = 32'h0a0a_0f02;
    want_dst_ip  = 32'h0a0a_0f03;
    want_port    = 16'd5602;
    want_udp_len = 16'd1480;
    want_magic   = 32'h5043_414d;
    clear_parse();
    seen_idx = '0;
    held = 0;
    cand_session = '0;
    cand_frame = '0;
    cand_live = 1'b0;
    total = '0;
    done = 1'b0;
  endfunction

  // One byte through the parser; returns 1 with a report at packet end
  function automatic bit step_assembler(input logic [7:0] b, input logic eop,
                                        output vfpa_result_t r);
    int u;
    int rel;
    int len;
    bit ok;
    bit took = 1'b0;
    bit over = 1'b0;
    bit done_now = 1'b0;
    r = '0;
    shreg = {shreg[55:0], b};
    if (pos == 5 && shreg[47:0] != want_dst_mac) bad = 1'b1;
    if (pos == 11 && shreg[47:0] != want_src_mac) bad = 1'b1;
    if (pos == 13 && shreg[15:0] != ETHERTYPE_IPV4) bad = 1'b1;
    if (pos == 14) begin
      ihl = b[3:0];
      if (b[7:4] != IP_VERSION_4 || b[3:0] < IP_MIN_IHL) bad = 1'b1;
    end
    if (pos == 23 && b != IP_PROTO_UDP) bad = 1'b1;
    if (pos == 29 && shreg[31:0] != want_src_ip) bad = 1'b1;
    if (pos == 33 && shreg[31:0] != want_dst_ip) bad = 1'b1;

    // UDP header and payload fields sit after the IP options
    u = 14 + 4 * int'(ihl);
    if (int'(pos) >= 34 && int'(pos) >= u) begin
      rel = int'(pos) - u;
      case (rel)
        1, 3: if (shreg[15:0] != want_port) bad = 1'b1;
        5: if (shreg[15:0] != want_udp_len) bad = 1'b1;
        11: if (shreg[31:0] != want_magic) bad = 1'b1;
        15: cur_session = shreg[31:0];
        19: cur_frame = shreg[31:0];
        21: cur_index = shreg[15:0];
        23: cur_flags = shreg[15:0];
        default: ;
      endcase
    end
    if (pos != POS_CAP) pos = pos + 16'd1;
    if (!eop) return 1'b0;

    len = int'(pos);
    ok = !bad && len >= u + 24 && cur_flags[0] && int'(cur_index) < PACKETS;
    if (ok && !done) begin
      // index 0 of another frame, or with nothing held, restarts the candidate
      if (cur_index == 16'd0 && (held == 0 || cur_session != cand_session ||
          cur_frame != cand_frame)) begin
        seen_idx = '0;
        held = 0;
        total = '0;
        cand_session = cur_session;
        cand_frame = cur_frame;
        cand_live = 1'b1;
      end
      if (cand_live && cur_session == cand_session && cur_frame == cand_frame &&
          !seen_idx[cur_index]) begin
        if (len > MAX_BYTES) begin
          over = 1'b1;
        end else begin
          seen_idx[cur_index] = 1'b1;
          held++;
          total = total + 32'(len);
          took = 1'b1;
          if (held == PACKETS) begin
            done_now = 1'b1;
            done = 1'b1;
          end
        end
      end
    end
    r.header_valid     = ok;
    r.session_value    = ok ? cur_session : '0;
    r.frame_value      = ok ? cur_frame : '0;
    r.index_value      = ok ? cur_index : '0;
    r.packet_accepted  = took;
    r.oversize         = over;
    r.collected_count  = 11'(held);
    r.frame_complete   = done_now;
    r.frame_byte_total = total[21:0];
    clear_parse();
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fails++;
      if (shown < 10) begin
        shown++;
        $display("MISMATCH %s: expected 0x%0h, actual 0x%0h", name, want, got);
      end
    end
  endfunction

  // Transaction monitor: compare results first, then predict from the byte
  always @(posedge clk) begin
    vfpa_result_t want;
    vfpa_result_t got;
    if (rst) begin
      reset_assembler();
      expected_reports.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SOURCE_MAC:       want_src_mac = cfg.data[47:0];
          REG_DEST_MAC:         want_dst_mac = cfg.data[47:0];
          REG_SOURCE_IP:        want_src_ip  = cfg.data[31:0];
          REG_DEST_IP:          want_dst_ip  = cfg.data[31:0];
          REG_UDP_PORT_NUMBER:  want_port    = cfg.data[15:0];
          REG_UDP_LENGTH_VALUE: want_udp_len = cfg.data[15:0];
          REG_PAYLOAD_MAGIC:    want_magic   = cfg.data[31:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        got.header_valid     = res.header_valid;
        got.session_value    = res.session_value;
        got.frame_value      = res.frame_value;
        got.index_value      = res.index_value;
        got.packet_accepted  = res.packet_accepted;
        got.oversize         = res.oversize;
        got.collected_count  = res.collected_count;
        got.frame_complete   = res.frame_complete;
        got.frame_byte_total = res.frame_byte_total;
        if (expected_reports.size() == 0) begin
          fails++;
          if (shown < 10) begin
            shown++;
            $display("MISMATCH unexpected result: actual 0x%0h", got);
          end
        end else begin
          want = expected_reports.pop_front();
          n_checked++;
          check_field("header_valid", 64'(want.header_valid), 64'(got.header_valid));
          check_field("session_value", 64'(want.session_value), 64'(got.session_value));
          check_field("frame_value", 64'(want.frame_value), 64'(got.frame_value));
          check_field("index_value", 64'(want.index_value), 64'(got.index_value));
          check_field("packet_accepted", 64'(want.packet_accepted),
                      64'(got.packet_accepted));
          check_field("oversize", 64'(want.oversize), 64'(got.oversize));
          check_field("collected_count", 64'(want.collected_count),
                      64'(got.collected_count));
          check_field("frame_complete", 64'(want.frame_complete), 64'(got.frame_complete));
          check_field("frame_byte_total", 64'(want.frame_byte_total),
                      64'(got.frame_byte_total));
        end
      end
      if (pkt.valid && pkt.ready) begin
        if (step_assembler(pkt.packet_byte, pkt.end_of_packet, want))
          expected_reports.push_back(want);
      end
    end
    fail_count <= fails;
    pending <= expected_reports.size();
    checked <= n_checked;
  end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Top of the assembler testbench: clock, reset, packet and register stimulus,
// random stalls on the result side, watchdog and verdict.
// Depends on vfpa_pkg, vfpa_if, vfpa_checker and the assembler RTL.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import vfpa_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PACKETS        = 1280;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum int {
    FLAW_NONE, FLAW_NOISE,
    FLAW_DST_MAC, FLAW_SRC_MAC, FLAW_ETHERTYPE, FLAW_VERSION, FLAW_SHORT_IHL,
    FLAW_PROTO, FLAW_SRC_IP, FLAW_DST_IP, FLAW_SRC_PORT, FLAW_DST_PORT,
    FLAW_UDP_LEN, FLAW_MAGIC, FLAW_FLAGS, FLAW_TRUNCATED
  } flaw_t;

  typedef enum int {SET_ZERO, SET_ONES, SET_RANDOM} reg_set_t;

  typedef struct {
    logic [31:0] session;
    logic [31:0] frame;
    logic [15:0] index;
    logic [15:0] flags;
    logic [3:0]  ihl;
    int          len;
    flaw_t       flaw;
  } pkt_desc_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vfpa_byte_if   pkt_if ();
  vfpa_result_if res_if ();
  vfpa_cfg_if    cfg_if ();

  int fail_count;
  int pending;
  int checked;

  bit   quiet = 1'b0;
  logic sink_ready = 1'b0;
  int   stall_left = 0;
  int   calm_left = 0;
  int   idle_cycles = 0;
  int   packets_sent = 0;

  // Register values as last written, used to build well-formed headers
  logic [47:0] m_src_mac = RST_SOURCE_MAC;
  logic [47:0] m_dst_mac = RST_DEST_MAC;
  logic [31:0] m_src_ip  = RST_SOURCE_IP;
  logic [31:0] m_dst_ip  = RST_DEST_IP;
  logic [15:0] m_port    = RST_UDP_PORT_NUMBER;
  logic [15:0] m_udp_len = RST_UDP_LENGTH_VALUE;
  logic [31:0] m_magic   = RST_PAYLOAD_MAGIC;

  logic [7:0] wire_bytes[$];

  video_frame_packet_assembler_unit u_top (
    .clk (clk),
    .rst (rst),
    .pkt (pkt_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  vfpa_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .pkt        (pkt_if),
    .res        (res_if),
    .cfg        (cfg_if),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  assign res_if.ready = sink_ready;

  // Result side stalls: random bursts with ready low, with calm stretches
  always @(posedge clk) begin
    if (rst || quiet) begin
      sink_ready <= 1'b1;
      stall_left <= 0;
      calm_left <= 0;
    end else if (stall_left > 0) begin
      sink_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (calm_left > 0) begin
      sink_ready <= 1'b1;
      calm_left <= calm_left - 1;
    end else if ($urandom_range(0, 99) == 0) begin
      sink_ready <= 1'b1;
      calm_left <= $urandom_range(50, 300);
    end else if ($urandom_range(0, 9) == 0) begin
      sink_ready <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (pkt_if.valid && pkt_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", idle_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [63:0] flip(logic [63:0] v, int n);
    return v ^ (64'd1 << $urandom_range(0, 8 * n - 1));
  endfunction

  function automatic pkt_desc_t good_desc(logic [31:0] s, logic [31:0] f, logic [15:0] i);
    pkt_desc_t d;
    d.session = s;
    d.frame = f;
    d.index = i;
    d.flags = 16'($urandom) | 16'h0001;
    d.ihl = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
    d.len = 14 + 4 * int'(d.ihl) + 24 + $urandom_range(0, 40);
    d.flaw = FLAW_NONE;
    return d;
  endfunction

  // Shortest or nearly shortest legal packet, for the long completion run
  function automatic pkt_desc_t tight_desc(logic [31:0] s, logic [31:0] f, logic [15:0] i);
    pkt_desc_t d;
    d = good_desc(s, f, i);
    d.ihl = 4'd5;
    d.len = 58 + $urandom_range(0, 3);
    return d;
  endfunction

  // Big-endian field write, clipped to the packet length
  task automatic put_field(int at, logic [63:0] v, int n);
    for (int k = 0; k < n; k++)
      if (at + k < wire_bytes.size()) wire_bytes[at + k] = v[8 * (n - 1 - k) +: 8];
  endtask

  task automatic build_packet(input pkt_desc_t d);
    int hl;
    int u;
    int n;
    logic [3:0] ver;
    logic [3:0] nib;
    logic [15:0] flags;
    hl = (d.ihl >= IP_MIN_IHL) ? int'(d.ihl) : int'(IP_MIN_IHL);
    u = 14 + 4 * hl;
    n = d.len;
    if (d.flaw == FLAW_TRUNCATED) n = $urandom_range(1, u + 23);
    wire_bytes.delete();
    for (int k = 0; k < n; k++) wire_bytes.push_back(8'($urandom));
    if (d.flaw == FLAW_NOISE) return;

    ver = IP_VERSION_4;
    if (d.flaw == FLAW_VERSION) begin
      ver = 4'($urandom_range(0, 14));
      if (ver >= IP_VERSION_4) ver = ver + 4'd1;
    end
    nib = (d.flaw == FLAW_SHORT_IHL) ? 4'($urandom_range(0, 4)) : d.ihl;
    flags = (d.flaw == FLAW_FLAGS) ? (d.flags & 16'hFFFE) : d.flags;

    put_field(0, (d.flaw == FLAW_DST_MAC) ? flip(m_dst_mac, 6) : 64'(m_dst_mac), 6);
    put_field(6, (d.flaw == FLAW_SRC_MAC) ? flip(m_src_mac, 6) : 64'(m_src_mac), 6);
    put_field(12, (d.flaw == FLAW_ETHERTYPE) ? flip(ETHERTYPE_IPV4, 2)
                                             : 64'(ETHERTYPE_IPV4), 2);
    put_field(14, {ver, nib}, 1);
    put_field(23, (d.flaw == FLAW_PROTO) ? flip(IP_PROTO_UDP, 1) : 64'(IP_PROTO_UDP), 1);
    put_field(26, (d.flaw == FLAW_SRC_IP) ? flip(m_src_ip, 4) : 64'(m_src_ip), 4);
    put_field(30, (d.flaw == FLAW_DST_IP) ? flip(m_dst_ip, 4) : 64'(m_dst_ip), 4);
    put_field(u, (d.flaw == FLAW_SRC_PORT) ? flip(m_port, 2) : 64'(m_port), 2);
    put_field(u + 2, (d.flaw == FLAW_DST_PORT) ? flip(m_port, 2) : 64'(m_port), 2);
    put_field(u + 4, (d.flaw == FLAW_UDP_LEN) ? flip(m_udp_len, 2) : 64'(m_udp_len), 2);
    put_field(u + 8, (d.flaw == FLAW_MAGIC) ? flip(m_magic, 4) : 64'(m_magic), 4);
    put_field(u + 12, d.session, 4);
    put_field(u + 16, d.frame, 4);
    put_field(u + 20, d.index, 2);
    put_field(u + 22, flags, 2);
  endtask

  // Byte stream out; some packets get random gaps between transactions
  task automatic send(input pkt_desc_t d);
    int last;
    bit gappy;
    build_packet(d);
    last = wire_bytes.size() - 1;
    gappy = !quiet && ($urandom_range(0, 2) != 0);
    for (int k = 0; k <= last; k++) begin
      pkt_if.valid <= 1'b1;
      pkt_if.packet_byte <= wire_bytes[k];
      pkt_if.end_of_packet <= (k == last);
      do @(posedge clk); while (!pkt_if.ready);
      if (gappy && $urandom_range(0, 11) == 0) begin
        pkt_if.valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
    packets_sent++;
  endtask

  // Drain all outstanding reports before touching registers
  task automatic settle();
    pkt_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [47:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= v;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_SOURCE_MAC:       m_src_mac = v;
      REG_DEST_MAC:         m_dst_mac = v;
      REG_SOURCE_IP:        m_src_ip = v[31:0];
      REG_DEST_IP:          m_dst_ip = v[31:0];
      REG_UDP_PORT_NUMBER:  m_port = v[15:0];
      REG_UDP_LENGTH_VALUE: m_udp_len = v[15:0];
      REG_PAYLOAD_MAGIC:    m_magic = v[31:0];
      default: ;
    endcase
  endtask

  function automatic logic [47:0] pick(reg_set_t kind);
    case (kind)
      SET_ZERO: return '0;
      SET_ONES: return '1;
      default:  return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic program_regs(reg_set_t kind);
    settle();
    write_reg(REG_SOURCE_MAC, pick(kind));
    write_reg(REG_DEST_MAC, pick(kind));
    write_reg(REG_SOURCE_IP, pick(kind));
    write_reg(REG_DEST_IP, pick(kind));
    write_reg(REG_UDP_PORT_NUMBER, pick(kind));
    write_reg(REG_UDP_LENGTH_VALUE, pick(kind));
    write_reg(REG_PAYLOAD_MAGIC, pick(kind));
    write_reg(REG_UNUSED, pick(SET_RANDOM));
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed packets of a few candidate frames, plus noise and faults
  task automatic random_phase(int count);
    logic [31:0] pool_s[3];
    logic [31:0] pool_f[3];
    logic [31:0] cs;
    logic [31:0] cf;
    pkt_desc_t d;
    int r;
    int p;
    for (int k = 0; k < 3; k++) begin
      pool_s[k] = $urandom;
      pool_f[k] = $urandom;
    end
    cs = pool_s[0];
    cf = pool_f[0];
    send(good_desc(cs, cf, 16'd0));
    repeat (count) begin
      r = $urandom_range(0, 99);
      p = $urandom_range(0, 2);
      d = good_desc(cs, cf, 16'($urandom_range(0, 31)));
      if (r < 8) begin
        d.flaw = FLAW_NOISE;
        d.len = $urandom_range(1, 80);
      end else if (r < 20) begin
        d.flaw = flaw_t'($urandom_range(int'(FLAW_DST_MAC), int'(FLAW_TRUNCATED)));
      end else if (r < 28) begin
        d.session = pool_s[p];
        d.frame = pool_f[$urandom_range(0, 2)];
      end else if (r < 36) begin
        cs = pool_s[p];
        cf = pool_f[p];
        d.session = cs;
        d.frame = cf;
        d.index = 16'd0;
      end else if (r < 40) begin
        d.len = $urandom_range(2049, 2100);
      end else if (r < 43) begin
        d.index = 16'($urandom_range(PACKETS, 65535));
      end
      send(d);
    end
  endtask

  // One whole frame in shuffled order with duplicates, then traffic after completion
  task automatic complete_frame();
    int order[$];
    int j;
    int tmp;
    logic [31:0] s;
    logic [31:0] f;
    pkt_desc_t d;
    s = $urandom;
    f = $urandom;
    for (int k = 1; k < PACKETS; k++) order.push_back(k);
    for (int k = order.size() - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    send(tight_desc(s, f, 16'd0));
    for (int k = 0; k < order.size(); k++) begin
      send(tight_desc(s, f, 16'(order[k])));
      if ($urandom_range(0, 24) == 0)
        send(tight_desc(s, f, 16'(order[$urandom_range(0, k)])));
      if ($urandom_range(0, 49) == 0)
        send(tight_desc(~s, f, 16'($urandom_range(1, PACKETS - 1))));
    end
    send(tight_desc(s, f, 16'd5));
    send(tight_desc(~s, f, 16'd0));
    send(tight_desc(~s, f, 16'd1));
    d = tight_desc(s, ~f, 16'd0);
    d.flaw = FLAW_MAGIC;
    send(d);
  endtask

  initial begin
    pkt_desc_t d;
    pkt_if.valid = 1'b0;
    pkt_if.packet_byte = '0;
    pkt_if.end_of_packet = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed packets under the reset register values
    d = good_desc('0, '0, 16'd0);
    d.flaw = FLAW_NOISE;
    d.len = 1;
    send(d);                                  // one-byte packet
    send(good_desc('0, '0, 16'd0));           // first candidate, all-zero ids
    send(good_desc('0, '0, 16'd0));           // duplicate
    send(good_desc('0, '0, 16'd1));
    d = good_desc('0, '0, 16'(PACKETS - 1));
    d.len = 2048;                             // largest index at largest length
    send(d);
    send(good_desc('0, '0, 16'(PACKETS)));    // index just out of range
    send(good_desc('0, '0, 16'hFFFF));
    send(good_desc(32'h0000_1234, '0, 16'd2)); // foreign session
    d = good_desc('0, '0, 16'd3);
    d.len = 2049;                             // one byte too long
    send(d);
    d = good_desc('0, '0, 16'd4);
    d.ihl = 4'd15;
    d.len = 14 + 60 + 24;                     // longest IP header, shortest payload
    send(d);
    for (int k = int'(FLAW_DST_MAC); k <= int'(FLAW_TRUNCATED); k++) begin
      d = good_desc('0, '0, 16'd5);
      d.flaw = flaw_t'(k);
      send(d);
    end
    d = good_desc('1, '1, 16'd0);
    d.len = 3000;                             // oversize restart of the candidate
    send(d);
    send(good_desc('1, '1, 16'd0));
    d = good_desc('1, '1, 16'd1);
    d.len = 66000;                            // length counter saturates
    send(d);

    // Random traffic under several register settings
    program_regs(SET_ZERO);
    random_phase(60);
    program_regs(SET_ONES);
    random_phase(60);
    program_regs(SET_RANDOM);
    random_phase(60);

    // Last part: no stalls, whole frame to completion
    quiet = 1'b1;
    program_regs(SET_RANDOM);
    complete_frame();

    settle();
    repeat (16) @(posedge clk);
    $display("Sent %0d packets under reset, all-zero, all-one and random registers;",
             packets_sent);
    $display("checked %0d reports, including one frame assembled to completion", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
